### rtl/sopq_pkg.sv
// Package for the searchable ordered packet queue: command and status codes, stream widths.
package sopq_pkg;

  // Command codes carried on in_tuser
  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_POP      = 2'd1,
    CMD_TAKE     = 2'd2,
    CMD_CONTAINS = 2'd3
  } cmd_t;

  // Status codes returned in the result transaction
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned HPORT_W = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned IN_W    = 32;
  localparam int unsigned OUT_W   = 40;

endpackage

### rtl/searchable_ordered_packet_queue.sv
// Searchable ordered packet queue: one entry memory with a search and compaction sequencer.
//
// Usage:
//   Input channel (in_*): one transaction per command. in_tuser holds the command
//   (push, pop, take newest matching id, contains id); in_tdata holds key_id and
//   handle_in. Result channel (out_*): exactly one transaction per command with
//   status, found flag, returned handle and id, and the entry count after the command.
//   Entries live in one memory of DEPTH words with a registered read port; entry 0
//   is the oldest. One command is in work at a time; in_tready is high only while
//   the sequencer is idle.
//   Work from input transaction to out_tvalid, one compare or one move per cycle:
//     push, or any command on an empty queue: straight to the response state
//     contains: entries scanned from the tail; take: scanned, then entries behind
//     the removed one moved; pop: the head, then all entries behind it moved.
//   The longest is a take of the head of a full queue; in_tready rises with out_tvalid.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending result;
//   memory contents are not cleared, no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the sequencer
//   waits with the next result until the register is free.
module searchable_ordered_packet_queue #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned HANDLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sopq_pkg::IN_W-1:0]    in_tdata,   // key_id[15:0], handle_in[31:16]
  input  logic [1:0]                   in_tuser,   // cmd[1:0]
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sopq_pkg::OUT_W-1:0]   out_tdata   // status[1:0], found[2],
                                                   // handle_out[18:3], id_out[34:19],
                                                   // count[39:35]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = sopq_pkg::KEY_W + HANDLE_WIDTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t                        state_r;
  sopq_pkg::cmd_t                cmd_r;
  logic [sopq_pkg::KEY_W-1:0]    key_r;
  logic [CW-1:0]                 occ_r;
  logic [AW-1:0]                 idx_r;

  // pending result
  sopq_pkg::status_t             res_status_r;
  logic                          res_found_r;
  logic [HANDLE_WIDTH-1:0]       res_hdl_r;
  logic [sopq_pkg::KEY_W-1:0]    res_id_r;

  logic                          out_tvalid_r;
  logic [sopq_pkg::OUT_W-1:0]    out_tdata_r;

  // entry memory
  logic [EW-1:0]                 mem [DEPTH];
  logic [EW-1:0]                 rd_data_r;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [EW-1:0]                 wr_data;

  logic                          in_fire;
  sopq_pkg::cmd_t                in_cmd;
  logic [sopq_pkg::KEY_W-1:0]    in_key;
  logic [31:0]                   in_hdl32;
  logic [HANDLE_WIDTH-1:0]       in_hdl;
  logic                          full;
  logic [CW-1:0]                 occ_m1;
  logic [CW-1:0]                 idx_p1;
  logic [CW-1:0]                 idx_p2;
  logic [sopq_pkg::KEY_W-1:0]    rd_id;
  logic [HANDLE_WIDTH-1:0]       rd_hdl;
  logic                          hit;
  logic [31:0]                   cnt32;
  logic [31:0]                   hdl32;
  logic                          resp_load;

  // input decode
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_cmd    = sopq_pkg::cmd_t'(in_tuser);
  assign in_key    = in_tdata[15:0];
  assign in_hdl32  = 32'(in_tdata[31:16]);
  assign in_hdl    = in_hdl32[HANDLE_WIDTH-1:0];

  assign full   = (occ_r == DEPTH_C);
  assign occ_m1 = occ_r - CW'(1);
  assign idx_p1 = CW'(idx_r) + CW'(1);
  assign idx_p2 = CW'(idx_r) + CW'(2);

  assign rd_id  = rd_data_r[EW-1:HANDLE_WIDTH];
  assign rd_hdl = rd_data_r[HANDLE_WIDTH-1:0];
  // pop always takes the head; take/contains compare the key
  assign hit    = (cmd_r == sopq_pkg::CMD_POP) || (rd_id == key_r);

  assign resp_load = !out_tvalid_r || out_tready;

  // memory address and write control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {in_key, in_hdl};
    case (state_r)
      S_IDLE: begin
        if (in_cmd == sopq_pkg::CMD_POP) begin
          rd_addr = '0;
        end else begin
          rd_addr = occ_m1[AW-1:0];
        end
        if (in_fire && in_cmd == sopq_pkg::CMD_PUSH && !full) begin
          wr_en   = 1'b1;
          wr_addr = occ_r[AW-1:0];
        end
      end
      S_SEARCH: begin
        if (hit) begin
          rd_addr = idx_p1[AW-1:0];
        end else begin
          rd_addr = idx_r - AW'(1);
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
        rd_addr = idx_p2[AW-1:0];
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // in the response state the load below decides tvalid
      if (out_tvalid_r && out_tready && state_r != S_RESP) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r       <= in_cmd;
            key_r       <= in_key;
            res_found_r <= 1'b0;
            res_hdl_r   <= '0;
            res_id_r    <= '0;
            case (in_cmd)
              sopq_pkg::CMD_PUSH: begin
                if (full) begin
                  res_status_r <= sopq_pkg::ST_FULL;
                end else begin
                  res_status_r <= sopq_pkg::ST_OK;
                  occ_r        <= occ_r + CW'(1);
                end
                state_r <= S_RESP;
              end
              sopq_pkg::CMD_POP: begin
                if (occ_r == '0) begin
                  res_status_r <= sopq_pkg::ST_EMPTY;
                  state_r      <= S_RESP;
                end else begin
                  idx_r   <= '0;
                  state_r <= S_SEARCH;
                end
              end
              default: begin
                if (occ_r == '0) begin
                  res_status_r <= sopq_pkg::ST_NOTFOUND;
                  state_r      <= S_RESP;
                end else begin
                  idx_r   <= occ_m1[AW-1:0];
                  state_r <= S_SEARCH;
                end
              end
            endcase
          end
        end
        // take/contains scan from the tail, one entry per cycle; pop matches the head
        S_SEARCH: begin
          if (hit) begin
            res_status_r <= sopq_pkg::ST_OK;
            res_found_r  <= 1'b1;
            if (cmd_r == sopq_pkg::CMD_CONTAINS) begin
              state_r <= S_RESP;
            end else begin
              res_hdl_r <= rd_hdl;
              res_id_r  <= rd_id;
              if (idx_p1 == occ_r) begin
                occ_r   <= occ_m1;
                state_r <= S_RESP;
              end else begin
                state_r <= S_SHIFT;
              end
            end
          end else if (idx_r == '0) begin
            res_status_r <= sopq_pkg::ST_NOTFOUND;
            state_r      <= S_RESP;
          end else begin
            idx_r <= idx_r - AW'(1);
          end
        end
        // close the gap: entry idx+1 moves to idx each cycle
        S_SHIFT: begin
          if (idx_p2 == occ_r) begin
            occ_r   <= occ_m1;
            state_r <= S_RESP;
          end else begin
            idx_r <= idx_p1[AW-1:0];
          end
        end
        S_RESP: begin
          if (resp_load) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {cnt32[sopq_pkg::COUNT_W-1:0], res_id_r,
                             hdl32[sopq_pkg::HPORT_W-1:0], res_found_r, res_status_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign cnt32 = 32'(occ_r);
  assign hdl32 = 32'(res_hdl_r);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // occupancy never passes the capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C)
    else $error("occupancy above capacity");

  // a successful push grows the queue by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd == sopq_pkg::CMD_PUSH && !full |=> occ_r == $past(occ_r) + CW'(1))
    else $error("push did not grow occupancy");

  // the compaction cursor stays below the last stored entry
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> idx_p2 <= occ_r)
    else $error("shift cursor out of range");

  // a new result only comes out of the response state
  a_resp_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response state");

endmodule
